@@ hw/rtl/swpf_pkg.sv @@
// Package for the sliding-window peak follower.
// Holds default parameter values, configuration width and reset value.
// No dependencies.
`default_nettype none

package swpf_pkg;

  // default sizing, handed to the top-level parameters
  localparam int MAX_WINDOW_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // window length register
  localparam int              CFG_BITS     = 13;
  localparam int              CFG_MAX      = (1 << CFG_BITS) - 1;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 13'd2204;

endpackage

`default_nettype wire

@@ hw/rtl/swpf_if.sv @@
// Valid/ready channel interfaces for the sliding-window peak follower.
// swpf_in_if carries a sample and its first flag; swpf_out_if carries the peak.
// No dependencies.
`default_nettype none

interface swpf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first;

  modport source (output valid, output sample, output first, input ready);
  modport sink   (input valid, input sample, input first, output ready);
endinterface

interface swpf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-2:0] peak;

  modport source (output valid, output peak, input ready);
  modport sink   (input valid, input peak, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sliding_window_peak_follower.sv @@
// Top level of the sliding-window peak follower (sliding window maximum).
// Depends on swpf_pkg, swpf_if (channel interfaces), swpf_ctrl, swpf_queue_mem.
//
//   port     dir  width            content
//   in_ch    in   SAMPLE_BITS + 1  signed sample, first flag
//   out_ch   out  SAMPLE_BITS - 1  peak of the window, floored at zero
//   cfg_*    in   13               window length, written with cfg_we
//
// An accepted item holds the sequencer in EVAL, which expires or drops one queue
// entry per step and then does the final push; the next item is accepted only after
// that push, when the result is registered. Reads come from the registered queue
// memory ports. Reset clears pointers, fill and position; the memory needs no
// clearing. A waiting result holds the sequencer only at the final push; the next
// item is accepted while a result waits.
`default_nettype none

module sliding_window_peak_follower
  import swpf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  swpf_in_if.sink                  in_ch,
  swpf_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int WIN_CAP    = (MAX_WINDOW < CFG_MAX) ? MAX_WINDOW : CFG_MAX;
  localparam int POS_BITS   = $clog2(WIN_CAP + 1);
  localparam int IDX_BITS   = $clog2(MAX_WINDOW);
  localparam int ENTRY_BITS = SAMPLE_BITS + POS_BITS;

  logic                  mem_wr_en;
  logic [IDX_BITS-1:0]   mem_wr_addr;
  logic [ENTRY_BITS-1:0] mem_wr_data;
  logic [IDX_BITS-1:0]   mem_head_addr;
  logic [ENTRY_BITS-1:0] mem_head_data;
  logic [IDX_BITS-1:0]   mem_tail_addr;
  logic [ENTRY_BITS-1:0] mem_tail_data;

  // sequencer
  swpf_ctrl #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .POS_BITS    (POS_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_sample     (in_ch.sample),
    .in_first      (in_ch.first),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_peak      (out_ch.peak),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_head_addr (mem_head_addr),
    .mem_head_data (mem_head_data),
    .mem_tail_addr (mem_tail_addr),
    .mem_tail_data (mem_tail_data)
  );

  // candidate queue ring
  swpf_queue_mem #(
    .MAX_WINDOW (MAX_WINDOW),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_a_addr (mem_head_addr),
    .rd_a_data (mem_head_data),
    .rd_b_addr (mem_tail_addr),
    .rd_b_data (mem_tail_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/swpf_queue_mem.sv @@
// Candidate queue storage: one ring of {value, position} entries.
// One write port, two registered read ports (head and tail side).
// Depends on swpf_pkg only for the default parameter values.
`default_nettype none

module swpf_queue_mem
  import swpf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int ENTRY_BITS = SAMPLE_BITS_DEF + CFG_BITS,
  localparam int IDX_BITS  = $clog2(MAX_WINDOW)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IDX_BITS-1:0]   wr_addr,
  input  wire logic [ENTRY_BITS-1:0] wr_data,
  input  wire logic [IDX_BITS-1:0]   rd_a_addr,
  output      logic [ENTRY_BITS-1:0] rd_a_data,
  input  wire logic [IDX_BITS-1:0]   rd_b_addr,
  output      logic [ENTRY_BITS-1:0] rd_b_data
);

  logic [ENTRY_BITS-1:0] mem [MAX_WINDOW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read ports, read-before-write on a collision
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/swpf_ctrl.sv @@
// Sequencer for the peak follower: window register, ring pointers, expiry
// and tail-drop loop over the queue memory, and the output register.
// Depends on swpf_pkg; drives swpf_queue_mem through its address/data ports.
`default_nettype none

module swpf_ctrl
  import swpf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int POS_BITS    = CFG_BITS,
  localparam int IDX_BITS   = $clog2(MAX_WINDOW),
  localparam int FILL_BITS  = $clog2(MAX_WINDOW + 1),
  localparam int ENTRY_BITS = SAMPLE_BITS + POS_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [CFG_BITS-1:0]           cfg_wdata,
  // input transaction
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_first,
  // result transaction
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [SAMPLE_BITS-2:0]        out_peak,
  // queue memory
  output      logic                          mem_wr_en,
  output      logic [IDX_BITS-1:0]           mem_wr_addr,
  output      logic [ENTRY_BITS-1:0]         mem_wr_data,
  output      logic [IDX_BITS-1:0]           mem_head_addr,
  input  wire logic [ENTRY_BITS-1:0]         mem_head_data,
  output      logic [IDX_BITS-1:0]           mem_tail_addr,
  input  wire logic [ENTRY_BITS-1:0]         mem_tail_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_WINDOW - 1);

  function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + IDX_BITS'(1);
  endfunction

  function automatic logic [IDX_BITS-1:0] ring_prev(input logic [IDX_BITS-1:0] i);
    ring_prev = (i == '0) ? LAST_IDX : i - IDX_BITS'(1);
  endfunction

  logic                          state_r, state_nxt;
  logic [CFG_BITS-1:0]           window_r;
  logic [POS_BITS-1:0]           win_r, win_nxt;
  logic [IDX_BITS-1:0]           head_r, head_nxt;
  logic [IDX_BITS-1:0]           tail_r, tail_nxt;
  logic [FILL_BITS-1:0]          fill_r, fill_nxt;
  logic [POS_BITS-1:0]           pos_r, pos_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-2:0]        peak_r, peak_nxt;

  logic [POS_BITS-1:0]           win_eff;
  logic [31:0]                   cfg_ext;
  logic signed [SAMPLE_BITS-1:0] head_val, tail_val, top_val;
  logic [POS_BITS-1:0]           head_pos, head_age;
  logic                          accept;

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  // zero means one, above the ring depth saturates
  always_comb begin
    cfg_ext = 32'(window_r);
    if (window_r == '0) begin
      win_eff = POS_BITS'(1);
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      win_eff = POS_BITS'(MAX_WINDOW);
    end else begin
      win_eff = POS_BITS'(window_r);
    end
  end

  assign head_val = mem_head_data[ENTRY_BITS-1:POS_BITS];
  assign head_pos = mem_head_data[POS_BITS-1:0];
  assign tail_val = mem_tail_data[ENTRY_BITS-1:POS_BITS];
  assign head_age = pos_r - head_pos;
  assign top_val  = (fill_r == '0) ? x_r : head_val;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // one pop or, when the output is free, the final push per EVAL cycle; reads follow the next pointers
  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    x_nxt         = x_r;
    peak_nxt      = peak_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = tail_r;
    mem_wr_data   = {x_r, pos_r};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt     = in_sample;
          win_nxt   = win_eff;
          state_nxt = ST_EVAL;
          if (in_first) begin
            head_nxt = '0;
            tail_nxt = '0;
            fill_nxt = '0;
            pos_nxt  = '0;
          end
        end
      end
      ST_EVAL: begin
        if ((fill_r != '0) && (head_age >= win_r)) begin
          // head candidate left the window
          head_nxt = ring_next(head_r);
          fill_nxt = fill_r - FILL_BITS'(1);
        end else if ((fill_r != '0) && !(tail_val > x_r)) begin
          // new sample dominates the tail candidate
          tail_nxt = ring_prev(tail_r);
          fill_nxt = fill_r - FILL_BITS'(1);
        end else if (!out_valid_r || out_ready) begin
          mem_wr_en     = 1'b1;
          tail_nxt      = ring_next(tail_r);
          fill_nxt      = fill_r + FILL_BITS'(1);
          pos_nxt       = pos_r + POS_BITS'(1);
          peak_nxt      = (top_val > 0) ? top_val[SAMPLE_BITS-2:0] : '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign mem_head_addr = head_nxt;
  assign mem_tail_addr = ring_prev(tail_nxt);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    x_r    <= x_nxt;
    peak_r <= peak_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_peak  = peak_r;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for sliding_window_peak_follower (sliding window maximum).
// Drives samples and window-length writes, predicts every peak and checks the results.
// Depends on swpf_pkg, swpf_if and the peak follower RTL.
`default_nettype none

module testbench;
  import swpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPAN_MAX = MAX_WINDOW_DEF;
  localparam int BITS     = SAMPLE_BITS_DEF;

  typedef enum logic [1:0] {ACT_SAMPLE, ACT_WINDOW, ACT_DRAIN} act_t;

  typedef struct {
    act_t                   act;
    logic signed [BITS-1:0] sample;
    logic                   opens;
    logic [CFG_BITS-1:0]    window;
    logic                   hurry;
  } step_t;

  typedef struct {
    logic signed [BITS-1:0] value;
    int unsigned            pos;
  } cand_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  swpf_in_if  #(.SAMPLE_BITS(BITS)) in_ch ();
  swpf_out_if #(.SAMPLE_BITS(BITS)) out_ch ();

  sliding_window_peak_follower i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // pending stimulus, expected peaks, predictor state
  step_t               script[$];
  logic [BITS-2:0]     expected_peaks[$];
  cand_t               cands[$];
  int unsigned         arrival;
  logic [CFG_BITS-1:0] window_reg;
  logic                rush;
  logic                pace_rush;
  int unsigned         failures;

  // window maximum over the most recent samples, floored at zero
  function automatic logic [BITS-2:0] follow_peak(logic signed [BITS-1:0] s, logic opens);
    int unsigned span;
    cand_t       fresh;
    span = (window_reg == 0) ? 1 : ((window_reg > SPAN_MAX) ? SPAN_MAX : window_reg);
    if (opens) begin
      cands.delete();
      arrival = 0;
    end
    // expire old candidates at the head
    while (cands.size() != 0 && (arrival - cands[0].pos) >= span)
      void'(cands.pop_front());
    // drop tail candidates not larger than the new sample
    while (cands.size() != 0 && cands[cands.size()-1].value <= s)
      void'(cands.pop_back());
    fresh.value = s;
    fresh.pos   = arrival;
    cands.push_back(fresh);
    arrival++;
    return (cands[0].value > 0) ? cands[0].value[BITS-2:0] : '0;
  endfunction

  function automatic int unsigned draw_gap();
    if (rush) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic add_sample(input int s, input logic opens);
    step_t st;
    st.act    = ACT_SAMPLE;
    st.sample = s[BITS-1:0];
    st.opens  = opens;
    st.window = '0;
    st.hurry  = pace_rush;
    script.push_back(st);
  endtask

  task automatic add_window(input int w);
    step_t st;
    st.act    = ACT_WINDOW;
    st.sample = '0;
    st.opens  = 1'b0;
    st.window = w[CFG_BITS-1:0];
    st.hurry  = pace_rush;
    script.push_back(st);
  endtask

  task automatic add_drain();
    step_t st;
    st.act    = ACT_DRAIN;
    st.sample = '0;
    st.opens  = 1'b0;
    st.window = '0;
    st.hurry  = pace_rush;
    script.push_back(st);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: launches samples, writes the window only while the block is idle
  int unsigned send_gap;
  int unsigned quiet;

  always @(posedge clk) begin : drive
    logic  nxt_valid;
    logic  nxt_we;
    step_t head;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      cfg_we      <= 1'b0;
      send_gap = 0;
      quiet    = 0;
    end else begin
      if (cfg_we)
        window_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        expected_peaks.push_back(follow_peak(in_ch.sample, in_ch.first));
      nxt_valid = in_ch.valid && !in_ch.ready;
      nxt_we    = 1'b0;
      if (expected_peaks.size() != 0 || nxt_valid)
        quiet = 0;
      else if (quiet < 16)
        quiet++;
      if (!nxt_valid && script.size() != 0) begin
        head = script[0];
        case (head.act)
          ACT_SAMPLE: begin
            if (send_gap != 0) begin
              send_gap--;
            end else begin
              in_ch.sample <= head.sample;
              in_ch.first  <= head.opens;
              rush         <= head.hurry;
              nxt_valid = 1'b1;
              void'(script.pop_front());
              send_gap = draw_gap();
            end
          end
          ACT_WINDOW: begin
            if (quiet >= 4) begin
              cfg_wdata <= head.window;
              nxt_we = 1'b1;
              void'(script.pop_front());
            end
          end
          default: begin
            if (quiet >= 4)
              void'(script.pop_front());
          end
        endcase
      end
      in_ch.valid <= nxt_valid;
      cfg_we      <= nxt_we;
    end
  end

  // monitor: random back-pressure, compares each peak with the oldest expectation
  int unsigned stall;

  always @(posedge clk) begin : watch
    logic            nxt_ready;
    logic [BITS-2:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall = 0;
    end else begin
      nxt_ready = out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_peaks.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("ERROR: unexpected transaction, peak=%0d", out_ch.peak);
        end else begin
          want = expected_peaks.pop_front();
          if (out_ch.peak !== want) begin
            failures++;
            if (failures <= 10)
              $display("ERROR: peak mismatch, expected %0d, actual %0d", want, out_ch.peak);
          end
        end
        stall = draw_gap();
        nxt_ready = (stall == 0);
      end else if (!out_ch.ready) begin
        if (stall != 0)
          stall--;
        nxt_ready = (stall == 0);
      end
      out_ch.ready <= nxt_ready;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int windows[11];
    int s;
    int style;
    int run_len;
    int left;
    int k;
    logic opens;

    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.first  = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rush         = 1'b0;
    pace_rush    = 1'b0;
    failures     = 0;
    window_reg   = WINDOW_RESET;
    arrival      = 0;
    rst_n        = 1'b0;

    // directed: reset window, samples before any first flag, extremes, equal values
    add_sample(-32768, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(0, 1'b0);
    add_sample(1, 1'b0);
    add_sample(32767, 1'b0);
    add_sample(32767, 1'b0);
    add_sample(100, 1'b0);
    add_sample(-32768, 1'b0);
    // first flag clears the history
    add_sample(-5, 1'b1);
    add_sample(7, 1'b0);
    add_sample(7, 1'b0);
    add_sample(3, 1'b0);
    add_drain();
    // window of one: peak of the current sample only
    add_window(1);
    add_sample(32767, 1'b0);
    add_sample(-32768, 1'b0);
    add_sample(21845, 1'b0);
    add_sample(-21846, 1'b0);
    add_sample(0, 1'b0);
    // window of zero behaves as one
    add_window(0);
    add_sample(12, 1'b0);
    add_sample(-12, 1'b0);
    add_window(2);
    add_sample(9, 1'b1);
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(8, 1'b0);
    add_sample(1, 1'b0);

    // deep queue, then the window shrinks mid-sound
    pace_rush = 1'b1;
    add_window(4096);
    add_sample(30000, 1'b1);
    for (k = 1; k < 70; k++)
      add_sample(30000 - 400 * k, 1'b0);
    add_window(3);
    for (k = 0; k < 10; k++)
      add_sample($urandom_range(0, 65535), 1'b0);
    pace_rush = 1'b0;
    add_window(8191);
    for (k = 0; k < 10; k++)
      add_sample(int'($urandom_range(0, 2000)) - 1000, 1'b0);

    // random phases over several window settings
    windows = '{3, 1, 0, 16, 4096, 8191, 2, 64, 4097, 0, 2204};
    windows[9] = $urandom_range(5, 300);
    foreach (windows[p]) begin
      pace_rush = ($urandom_range(0, 3) == 0);
      add_window(windows[p]);
      left = 30;
      opens = $urandom_range(0, 1);
      while (left > 0) begin
        style   = $urandom_range(0, 3);
        run_len = $urandom_range(4, 12);
        s       = int'($urandom_range(0, 65535)) - 32768;
        for (k = 0; k < run_len && left > 0; k++) begin
          case (style)
            0: s = int'($urandom_range(0, 65535)) - 32768;
            1: s = int'($urandom_range(0, 8)) - 4;
            2: s = s - int'($urandom_range(0, 600));
            default: s = s + int'($urandom_range(0, 600));
          endcase
          if (s > 32767) s = 32767;
          if (s < -32768) s = -32768;
          add_sample(s, opens || ($urandom_range(0, 24) == 0));
          opens = 1'b0;
          left--;
        end
      end
      if (p == 5)
        add_drain();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sample the progress between edges so the driver's updates have settled
    while (script.size() != 0 || in_ch.valid || expected_peaks.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);

    failures += expected_peaks.size();
    if (failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
